// ===== rtl/core/cssed_pkg.sv =====
// ============================================================================
// cssed_pkg
// Shared types, constants and helpers for the CSS escape decoder.
// ============================================================================
`default_nettype none

package cssed_pkg;

    localparam int unsigned HEX_MAX     = 6;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned DIG_W       = 4 * HEX_MAX;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] FW_LOW    = 8'h01;
    localparam logic [7:0] FW_HIGH   = 8'h5E;
    localparam logic [7:0] FW_OFFSET = 8'h20;
    localparam logic [DIG_W-9:0] FW_PREFIX = (DIG_W-8)'('hFF);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_BSLASH = 2'd1,
        MODE_HEX    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_string;
        logic       changed;
    } t_result;

    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
    } t_entry;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end
        return v;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Low byte of the digits, shifted from full-width to plain ASCII for ffXX forms.
    function automatic logic [7:0] hex_value(input logic [DIG_W-1:0] dig,
                                             input logic [CNT_W-1:0] cnt);
        logic [7:0] b;
        b = dig[7:0];
        if (cnt >= CNT_W'(4) && dig[DIG_W-1:8] == FW_PREFIX &&
            b >= FW_LOW && b <= FW_HIGH) begin
            b = b + FW_OFFSET;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cssed_in_if.sv =====
// ============================================================================
// cssed_in_if
// Input byte channel: valid/ready with one raw string byte.
// ============================================================================
`default_nettype none

interface cssed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last;

    modport source (output valid, output in_byte, output last, input ready);
    modport sink   (input valid, input in_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cssed_out_if.sv =====
// ============================================================================
// cssed_out_if
// Output result channel: valid/ready with one decoded result word.
// ============================================================================
`default_nettype none

interface cssed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_string;
    logic       changed;

    modport source (output valid, output out_byte, output byte_valid,
                    output end_of_string, output changed, input ready);
    modport sink   (input valid, input out_byte, input byte_valid,
                    input end_of_string, input changed, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/cssed_front.sv =====
// ============================================================================
// cssed_front
// Accepts bytes, tracks escape state and classifies each byte into
// zero, one or two result words for the queue.
// ============================================================================
`default_nettype none

module cssed_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    cssed_in_if.sink              i_in,
    input  wire cssed_pkg::t_q_stat i_q_stat,
    output logic                  o_push,
    output cssed_pkg::t_entry     o_entry
);
    import cssed_pkg::*;

    t_mode            r_mode, n_mode;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [DIG_W-1:0] r_dig,  n_dig;
    logic             r_chg,  n_chg;

    logic [7:0] w_c;
    logic [3:0] w_nib;
    logic       w_hex;
    logic [7:0] w_b0, w_b1;
    logic [1:0] w_n;
    logic       w_accept;
    logic       w_eos0;

    assign w_c      = i_in.in_byte;
    assign w_nib    = nibble_of(w_c);
    assign w_hex    = is_hex(w_c);
    assign i_in.ready = !i_q_stat.full;
    assign w_accept = i_in.valid && i_in.ready;

    always_comb begin
        n_mode = r_mode;
        n_cnt  = r_cnt;
        n_dig  = r_dig;
        n_chg  = r_chg;
        w_b0   = '0;
        w_b1   = '0;
        w_n    = 2'd0;
        unique case (r_mode)
            MODE_BSLASH: begin
                if (w_hex) begin
                    n_dig  = DIG_W'(w_nib);
                    n_cnt  = CNT_W'(1);
                    n_chg  = 1'b1;
                    n_mode = MODE_HEX;
                    if (i_in.last) begin
                        w_b0 = {4'h0, w_nib};
                        w_n  = 2'd1;
                    end
                end else if (w_c == CH_LF) begin
                    n_chg  = 1'b1;
                    n_mode = MODE_NORMAL;
                end else begin
                    w_b0   = w_c;
                    w_n    = 2'd1;
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_HEX: begin
                if (w_hex && r_cnt < CNT_W'(HEX_MAX)) begin
                    n_dig = {r_dig[DIG_W-5:0], w_nib};
                    n_cnt = r_cnt + CNT_W'(1);
                    if (i_in.last) begin
                        w_b0 = hex_value(n_dig, n_cnt);
                        w_n  = 2'd1;
                    end
                end else begin
                    w_b0   = hex_value(r_dig, r_cnt);
                    w_n    = 2'd1;
                    n_cnt  = '0;
                    n_dig  = '0;
                    n_mode = MODE_NORMAL;
                    if (!is_ws(w_c)) begin
                        if (w_c == CH_BSLASH) begin
                            if (i_in.last) begin
                                n_chg = 1'b1;
                            end else begin
                                n_mode = MODE_BSLASH;
                            end
                        end else begin
                            w_b1 = w_c;
                            w_n  = 2'd2;
                        end
                    end
                end
            end
            default: begin
                if (w_c == CH_BSLASH) begin
                    if (i_in.last) begin
                        n_chg = 1'b1;
                    end else begin
                        n_mode = MODE_BSLASH;
                    end
                end else begin
                    w_b0   = w_c;
                    w_n    = 2'd1;
                    n_mode = MODE_NORMAL;
                end
            end
        endcase
    end

    // End of string rides on the last word; a byteless end gets an empty word.
    assign w_eos0 = i_in.last && (w_n != 2'd2);

    always_comb begin
        o_entry.res0.out_byte      = w_b0;
        o_entry.res0.byte_valid    = (w_n != 2'd0);
        o_entry.res0.end_of_string = w_eos0;
        o_entry.res0.changed       = w_eos0 && n_chg;
        o_entry.res1.out_byte      = w_b1;
        o_entry.res1.byte_valid    = 1'b1;
        o_entry.res1.end_of_string = i_in.last;
        o_entry.res1.changed       = i_in.last && n_chg;
        o_entry.two                = (w_n == 2'd2);
        o_push                     = w_accept && ((w_n != 2'd0) || i_in.last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_cnt  <= '0;
            r_dig  <= '0;
            r_chg  <= 1'b0;
        end else if (w_accept) begin
            if (i_in.last) begin
                r_mode <= MODE_NORMAL;
                r_cnt  <= '0;
                r_dig  <= '0;
                r_chg  <= 1'b0;
            end else begin
                r_mode <= n_mode;
                r_cnt  <= n_cnt;
                r_dig  <= n_dig;
                r_chg  <= n_chg;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cssed_queue.sv =====
// ============================================================================
// cssed_queue
// Small register FIFO of classified entries between front and back.
// ============================================================================
`default_nettype none

module cssed_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire cssed_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output cssed_pkg::t_q_stat    o_stat,
    output cssed_pkg::t_entry     o_entry
);
    import cssed_pkg::*;

    t_entry            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_push, w_pop;

    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_entry      = r_mem[r_rd];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && o_stat.valid;

    always_comb begin
        n_wr  = w_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = w_pop ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cssed_back.sv =====
// ============================================================================
// cssed_back
// Drains queue entries one word at a time into the output register.
// ============================================================================
`default_nettype none

module cssed_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire cssed_pkg::t_q_stat i_q_stat,
    input  wire cssed_pkg::t_entry i_entry,
    output logic                  o_pop,
    cssed_out_if.source           o_out
);
    import cssed_pkg::*;

    logic    r_valid;
    logic    r_sub;
    t_result r_res;
    logic    w_load;

    assign w_load = !r_valid || o_out.ready;
    assign o_pop  = w_load && i_q_stat.valid && (!i_entry.two || r_sub);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_q_stat.valid;
            if (i_q_stat.valid) begin
                r_sub <= i_entry.two && !r_sub;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_q_stat.valid) begin
            r_res <= r_sub ? i_entry.res1 : i_entry.res0;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.out_byte      = r_res.out_byte;
    assign o_out.byte_valid    = r_res.byte_valid;
    assign o_out.end_of_string = r_res.end_of_string;
    assign o_out.changed       = r_res.changed;

endmodule

`default_nettype wire

// ===== rtl/core/css_escape_decode_core.sv =====
// ============================================================================
// css_escape_decode_core
// CSS backslash-escape decoder: bytes in, decoded words out.
// ============================================================================
//  channel   dir  handshake     payload
//  i_in      in   valid/ready   in_byte[7:0], last
//  o_out     out  valid/ready   out_byte[7:0], byte_valid, end_of_string, changed
//
//  One byte accepted per cycle while the queue is not full; its words pass
//  through the queue into the output register.
//  A byte that closes a hex escape with a following plain byte yields two
//  words, which leave one at a time; the 4-entry queue absorbs short runs
//  of them, and a long run fills it and stalls the input.
//  Synchronous reset clears escape state, empties the queue, drops o_out.valid.
//  i_in.ready falls only when the queue is full.
// ============================================================================
`default_nettype none

module css_escape_decode_core (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    cssed_in_if.sink    i_in,
    cssed_out_if.source o_out
);
    import cssed_pkg::*;

    logic    w_push, w_pop;
    t_entry  w_push_entry, w_head;
    t_q_stat w_q_stat;

    cssed_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    cssed_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_entry (w_head)
    );

    cssed_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_entry  (w_head),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> w_q_stat.valid)
        else $error("queue full while empty");

    a_changed_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.end_of_string || !o_out.changed))
        else $error("changed flag before end of string");

    a_empty_word_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.byte_valid) |->
            (o_out.end_of_string && o_out.out_byte == 8'h00))
        else $error("byteless word not at end of string");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("push into full queue");

endmodule

`default_nettype wire
